// ----- src/midi_event_note_off_scheduler_core_defines.svh -----
// Assertion macros shared by the note-off scheduler modules.
// No dependencies; included by the modules that carry assertions.
`ifndef MIDI_EVENT_NOTE_OFF_SCHEDULER_CORE_DEFINES_SVH
`define MIDI_EVENT_NOTE_OFF_SCHEDULER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNOS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MNOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/mnos_pkg.sv -----
// Shared types and constants of the MIDI note-off scheduler.
// No dependencies; imported by every module of the block.
package mnos_pkg;

   localparam int SLOTS_DEFAULT = 16;

   // Command queue between front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Request codes.
   localparam logic [3:0] REQ_NOTE_ON   = 4'd0;
   localparam logic [3:0] REQ_NOTE_OFF  = 4'd1;
   localparam logic [3:0] REQ_CC        = 4'd2;
   localparam logic [3:0] REQ_TIMED     = 4'd3;
   localparam logic [3:0] REQ_CLOCK     = 4'd4;
   localparam logic [3:0] REQ_START     = 4'd5;
   localparam logic [3:0] REQ_CONTINUE  = 4'd6;
   localparam logic [3:0] REQ_STOP      = 4'd7;
   localparam logic [3:0] REQ_TICK      = 4'd8;
   localparam logic [3:0] REQ_ALL_OFF   = 4'd9;
   localparam logic [3:0] REQ_PANIC     = 4'd10;

   // MIDI status bytes and controller numbers.
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_CC       = 8'hB0;
   localparam logic [7:0] STATUS_CLOCK    = 8'hF8;
   localparam logic [7:0] STATUS_START    = 8'hFA;
   localparam logic [7:0] STATUS_CONTINUE = 8'hFB;
   localparam logic [7:0] STATUS_STOP     = 8'hFC;
   localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
   localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
   localparam logic [3:0] LAST_CHANNEL     = 4'hF;

   localparam logic [1:0] COUNT_CHANNEL  = 2'd3;
   localparam logic [1:0] COUNT_REALTIME = 2'd1;

   typedef enum logic [2:0] {
      OP_SINGLE,
      OP_NOTE_OFF,
      OP_TIMED,
      OP_TICK,
      OP_ALL_OFF,
      OP_PANIC
   } op_kind_type;

   typedef struct packed {
      op_kind_type op;
      logic [7:0]  status;
      logic [6:0]  first_data;
      logic [6:0]  second_data;
      logic [1:0]  byte_count;
      logic [3:0]  channel;
      logic [6:0]  key;
      logic [15:0] length;
      logic [31:0] tick;
   } cmd_type;

endpackage

// ----- src/mnos_front.sv -----
// Front end: accepts requests and decodes them into queue commands.
// Depends on mnos_pkg.
module mnos_front import mnos_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_key_or_controller,
   input  logic [6:0]  req_velocity_or_value,
   input  logic [15:0] req_length_ticks,
   input  logic [31:0] req_tick_now,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic keep;

   always_comb begin
      keep               = 1'b1;
      q_cmd.op           = OP_SINGLE;
      q_cmd.status       = STATUS_NOTE_ON | {4'h0, req_channel};
      q_cmd.first_data   = req_key_or_controller;
      q_cmd.second_data  = req_velocity_or_value;
      q_cmd.byte_count   = COUNT_CHANNEL;
      q_cmd.channel      = req_channel;
      q_cmd.key          = req_key_or_controller;
      q_cmd.length       = req_length_ticks;
      q_cmd.tick         = req_tick_now;
      case (req_type)
         REQ_NOTE_ON: begin
            q_cmd.op = OP_SINGLE;
         end
         REQ_NOTE_OFF: begin
            q_cmd.op     = OP_NOTE_OFF;
            q_cmd.status = STATUS_NOTE_OFF | {4'h0, req_channel};
         end
         REQ_CC: begin
            q_cmd.status = STATUS_CC | {4'h0, req_channel};
         end
         REQ_TIMED: begin
            q_cmd.op = OP_TIMED;
         end
         REQ_CLOCK, REQ_START, REQ_CONTINUE, REQ_STOP: begin
            q_cmd.first_data  = 7'd0;
            q_cmd.second_data = 7'd0;
            q_cmd.byte_count  = COUNT_REALTIME;
            if (req_type == REQ_CLOCK) begin
               q_cmd.status = STATUS_CLOCK;
            end else if (req_type == REQ_START) begin
               q_cmd.status = STATUS_START;
            end else if (req_type == REQ_CONTINUE) begin
               q_cmd.status = STATUS_CONTINUE;
            end else begin
               q_cmd.status = STATUS_STOP;
            end
         end
         REQ_TICK: begin
            q_cmd.op = OP_TICK;
         end
         REQ_ALL_OFF: begin
            q_cmd.op = OP_ALL_OFF;
         end
         REQ_PANIC: begin
            q_cmd.op = OP_PANIC;
         end
         default: begin
            // Unknown requests are taken and dropped.
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

// ----- src/mnos_queue.sv -----
// Short command queue that decouples the decoder from the sequencer.
// Depends on mnos_pkg and the shared assertion macros.
`include "midi_event_note_off_scheduler_core_defines.svh"

module mnos_queue import mnos_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   `MNOS_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= Q_CNT_W'(Q_DEPTH))

endmodule

// ----- src/mnos_back.sv -----
// Back end: sequencer that owns the note-off table and emits MIDI words.
// Depends on mnos_pkg and the shared assertion macros.
`include "midi_event_note_off_scheduler_core_defines.svh"

module mnos_back import mnos_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_status,
   output logic [6:0]  rsp_out_first_data,
   output logic [6:0]  rsp_out_second_data,
   output logic [1:0]  rsp_byte_count,
   output logic        rsp_no_free_slot,
   output logic        rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MSG,
      S_SCAN_MATCH,
      S_SCAN_FREE,
      S_SCAN_EXP,
      S_TICK_END,
      S_CC
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               full_ff, full_in;
   logic [31:0]        current_tick_ff, current_tick_in;
   logic [SLOTS-1:0]   active_ff, active_in;
   logic               held_ff, held_in;
   logic [3:0]         held_ch_ff, held_ch_in;
   logic [6:0]         held_note_ff, held_note_in;
   logic [3:0]         cc_chan_ff, cc_chan_in;
   logic               cc_phase_ff, cc_phase_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_status_ff, rsp_status_in;
   logic [6:0]         rsp_first_ff, rsp_first_in;
   logic [6:0]         rsp_second_ff, rsp_second_in;
   logic [1:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [3:0]         slot_channel_ff [SLOTS];
   logic [6:0]         slot_note_ff [SLOTS];
   logic [31:0]        slot_off_tick_ff [SLOTS];
   logic               slot_we;
   logic [31:0]        slot_off_in;

   logic               can_put;
   logic               cur_active;
   logic [3:0]         cur_channel;
   logic [6:0]         cur_note;
   logic               cur_expired;
   logic               exp_stall;
   logic               panic_done;

   assign can_put     = !rsp_valid_ff || rsp_ready;
   assign cur_active  = active_ff[idx_ff];
   assign cur_channel = slot_channel_ff[idx_ff];
   assign cur_note    = slot_note_ff[idx_ff];
   assign cur_expired = cur_active && (current_tick_ff >= slot_off_tick_ff[idx_ff]);
   assign exp_stall   = (state_ff == S_SCAN_EXP) && cur_expired && held_ff && !can_put;
   assign slot_off_in = current_tick_ff + {16'h0000, cmd_ff.length};
   assign panic_done  = (state_ff == S_CC) && can_put && cc_phase_ff &&
                        (cmd_ff.op == OP_PANIC) && (cc_chan_ff == LAST_CHANNEL);

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      idx_in          = idx_ff;
      full_in         = full_ff;
      current_tick_in = current_tick_ff;
      active_in       = active_ff;
      held_in         = held_ff;
      held_ch_in      = held_ch_ff;
      held_note_in    = held_note_ff;
      cc_chan_in      = cc_chan_ff;
      cc_phase_in     = cc_phase_ff;
      slot_we         = 1'b0;
      q_pop           = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_second_in   = rsp_second_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               cmd_in  = q_cmd;
               idx_in  = '0;
               full_in = 1'b0;
               held_in = 1'b0;
               cc_phase_in = 1'b0;
               case (q_cmd.op)
                  OP_SINGLE:   state_in = S_MSG;
                  OP_NOTE_OFF: state_in = S_SCAN_MATCH;
                  OP_TIMED:    state_in = S_SCAN_FREE;
                  OP_TICK: begin
                     current_tick_in = q_cmd.tick;
                     state_in        = S_SCAN_EXP;
                  end
                  OP_ALL_OFF: begin
                     cc_chan_in = q_cmd.channel;
                     state_in   = S_CC;
                  end
                  OP_PANIC: begin
                     cc_chan_in = 4'h0;
                     state_in   = S_CC;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MSG: begin
            if (can_put) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cmd_ff.status;
               rsp_first_in  = cmd_ff.first_data;
               rsp_second_in = cmd_ff.second_data;
               rsp_count_in  = cmd_ff.byte_count;
               rsp_full_in   = full_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN_MATCH: begin
            if (cur_active && cur_channel == cmd_ff.channel && cur_note == cmd_ff.key) begin
               active_in[idx_ff] = 1'b0;
               state_in          = S_MSG;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_MSG;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SCAN_FREE: begin
            if (!cur_active) begin
               active_in[idx_ff] = 1'b1;
               slot_we           = 1'b1;
               state_in          = S_MSG;
            end else if (idx_ff == LAST_IDX) begin
               full_in  = 1'b1;
               state_in = S_MSG;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SCAN_EXP: begin
            // An expired slot is held back one find, so the final note-off
            // can be marked last once the scan is over.
            if (!exp_stall) begin
               if (cur_expired) begin
                  if (held_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_NOTE_OFF | {4'h0, held_ch_ff};
                     rsp_first_in  = held_note_ff;
                     rsp_second_in = 7'd0;
                     rsp_count_in  = COUNT_CHANNEL;
                     rsp_full_in   = 1'b0;
                     rsp_last_in   = 1'b0;
                  end
                  held_in           = 1'b1;
                  held_ch_in        = cur_channel;
                  held_note_in      = cur_note;
                  active_in[idx_ff] = 1'b0;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_TICK_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_TICK_END: begin
            if (!held_ff) begin
               state_in = S_IDLE;
            end else if (can_put) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOTE_OFF | {4'h0, held_ch_ff};
               rsp_first_in  = held_note_ff;
               rsp_second_in = 7'd0;
               rsp_count_in  = COUNT_CHANNEL;
               rsp_full_in   = 1'b0;
               rsp_last_in   = 1'b1;
               held_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_CC: begin
            if (can_put) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_CC | {4'h0, cc_chan_ff};
               rsp_first_in  = cc_phase_ff ? CC_ALL_SOUND_OFF : CC_ALL_NOTES_OFF;
               rsp_second_in = 7'd0;
               rsp_count_in  = COUNT_CHANNEL;
               rsp_full_in   = 1'b0;
               rsp_last_in   = cc_phase_ff &&
                               (cmd_ff.op == OP_ALL_OFF || cc_chan_ff == LAST_CHANNEL);
               if (!cc_phase_ff) begin
                  cc_phase_in = 1'b1;
               end else begin
                  cc_phase_in = 1'b0;
                  if (cmd_ff.op == OP_ALL_OFF) begin
                     state_in = S_IDLE;
                  end else if (cc_chan_ff == LAST_CHANNEL) begin
                     active_in = '0;
                     state_in  = S_IDLE;
                  end else begin
                     cc_chan_in = cc_chan_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         active_ff       <= '0;
         current_tick_ff <= '0;
         held_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_ff       <= active_in;
         current_tick_ff <= current_tick_in;
         held_ff         <= held_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      full_ff       <= full_in;
      held_ch_ff    <= held_ch_in;
      held_note_ff  <= held_note_in;
      cc_chan_ff    <= cc_chan_in;
      cc_phase_ff   <= cc_phase_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_channel_ff[idx_ff]  <= cmd_ff.channel;
         slot_note_ff[idx_ff]     <= cmd_ff.key;
         slot_off_tick_ff[idx_ff] <= slot_off_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_status      = rsp_status_ff;
   assign rsp_out_first_data  = rsp_first_ff;
   assign rsp_out_second_data = rsp_second_ff;
   assign rsp_byte_count      = rsp_count_ff;
   assign rsp_no_free_slot    = rsp_full_ff;
   assign rsp_last            = rsp_last_ff;

   // A word that is not the last of its request leaves the sequencer busy.
   `MNOS_ASSERT_HOLDS(a_not_last_busy, clock, reset, rsp_valid_ff && !rsp_last_ff, state_ff != S_IDLE)
   // A stalled expiry scan keeps its place and its held note-off.
   `MNOS_ASSERT_NEXT(a_scan_stall, clock, reset, exp_stall, $stable(idx_ff) && held_ff)
   // The final panic word empties the note-off table.
   `MNOS_ASSERT_NEXT(a_panic_clear, clock, reset, panic_done, active_ff == '0)

endmodule

// ----- src/midi_event_note_off_scheduler_core.sv -----
// MIDI event scheduler with a pending note-off table of SLOTS entries.
// Single messages are put out directly; note-off, timed-note and tick requests
// first scan the slots, and a tick puts out its note-offs during its scan.
// The sequencer walks the table one slot per cycle, except that a tick scan waits
// while a held note-off cannot be put out; the queue takes requests until it is full.
// Reset clears the active flags, the current tick and the command queue.
module midi_event_note_off_scheduler_core import mnos_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_key_or_controller,
   input  logic [6:0]  req_velocity_or_value,
   input  logic [15:0] req_length_ticks,
   input  logic [31:0] req_tick_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_status,
   output logic [6:0]  rsp_out_first_data,
   output logic [6:0]  rsp_out_second_data,
   output logic [1:0]  rsp_byte_count,
   output logic        rsp_no_free_slot,
   output logic        rsp_last
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_head_cmd;

   mnos_front u_front (
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_channel           (req_channel),
      .req_key_or_controller (req_key_or_controller),
      .req_velocity_or_value (req_velocity_or_value),
      .req_length_ticks      (req_length_ticks),
      .req_tick_now          (req_tick_now),
      .q_full                (q_full),
      .q_push                (q_push),
      .q_cmd                 (q_push_cmd)
   );

   mnos_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head_cmd)
   );

   mnos_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_not_empty         (q_not_empty),
      .q_cmd               (q_head_cmd),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_status      (rsp_out_status),
      .rsp_out_first_data  (rsp_out_first_data),
      .rsp_out_second_data (rsp_out_second_data),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_no_free_slot    (rsp_no_free_slot),
      .rsp_last            (rsp_last)
   );

endmodule
